/* rtl/fgn_pkg.sv */
// shared constants, tables and arithmetic helpers for the fractal gradient noise block
package fgn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [31:0] H_SEED    = 32'd374761393;
    localparam logic [31:0] H_X       = 32'd668265263;
    localparam logic [31:0] H_Y       = 32'd2246822519;
    localparam logic [31:0] H_Z       = 32'd3266489917;
    localparam logic [31:0] H_MIX     = 32'd1274126177;
    localparam logic [31:0] SEED_STEP = 32'd1013;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx REG_NOISE_SEED   = 1'b0;
    localparam t_cfg_idx REG_OCTAVE_COUNT = 1'b1;

    // Q1.16 reciprocal of the summed octave amplitudes, zero octaves gives zero
    function automatic logic [16:0] norm_recip(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd43691;
            4'd3:    r = 17'd37449;
            4'd4:    r = 17'd34953;
            4'd5:    r = 17'd33825;
            4'd6:    r = 17'd33288;
            4'd7:    r = 17'd33026;
            4'd8:    r = 17'd32897;
            4'd9:    r = 17'd32832;
            4'd10:   r = 17'd32800;
            4'd11:   r = 17'd32784;
            4'd12:   r = 17'd32776;
            4'd13:   r = 17'd32772;
            4'd14:   r = 17'd32770;
            4'd15:   r = 17'd32769;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // hash offset of a cube corner: bit 0 steps x, bit 1 steps y, bit 2 steps z
    function automatic logic [31:0] corner_off(input int c);
        logic [31:0] s;
        s = 32'd0;
        if ((c & 1) != 0) s = s + H_X;
        if ((c & 2) != 0) s = s + H_Y;
        if ((c & 4) != 0) s = s + H_Z;
        return s;
    endfunction

    // dot product with a cube edge gradient picked by the 4-bit hash code h
    function automatic logic signed [18:0] grad_dot(input logic [3:0] h,
                                                    input logic signed [16:0] dx,
                                                    input logic signed [16:0] dy,
                                                    input logic signed [16:0] dz);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(dx) : 19'(dy);
        if (h < 4'd4)
            v = 19'(dy);
        else if (h == 4'd12 || h == 4'd14)
            v = 19'(dx);
        else
            v = 19'(dz);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // a + floor(w * (b - a) / 2^16)
    function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic [16:0] w);
        logic signed [20:0] d;
        logic signed [38:0] pr;
        d  = 21'(b) - 21'(a);
        pr = 39'($signed({1'b0, w})) * 39'(d);
        return a + 20'(pr >>> 16);
    endfunction

endpackage

/* rtl/fgn_pt_if.sv */
// point and noise sample channels
interface fgn_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface fgn_nv_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

/* rtl/fractal_gradient_noise_3d.sv */
// fractal gradient noise top level: twelve-stage pipeline, all octaves side by side
// A point (signed fixed point, FRAC_BITS fraction bits) enters on i_point and one
// saturated Q1.15 noise sample leaves on o_noise. One point is taken every cycle unless
// stalled: every octave has its own hash multipliers, fade and blend lanes, and the
// octave sum and normalization follow in a short registered tree. o_noise backpressure
// holds the whole pipeline; no beat is lost or repeated. The user must write noise_seed
// and octave_count through i_cfg only while no point is in flight; the block does not
// enforce this. Counts above MAX_OCTAVES act as MAX_OCTAVES; zero octaves yield zero.
module fractal_gradient_noise_3d #(
    parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fgn_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  fgn_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    fgn_pt_if.sink            i_point,
    fgn_nv_if.source          o_noise
);
    import fgn_pkg::*;

    localparam int          NG    = (MAX_OCTAVES + 3) / 4;
    localparam int          FSH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int          FSH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
    localparam int          NST   = 12;

    logic [31:0] r_seed;
    logic [3:0]  r_count;
    logic [NST:1] r_vld;
    logic        en;

    logic [31:0] pt [3];
    logic [31:0] lat [MAX_OCTAVES][3];
    logic [15:0] fr  [MAX_OCTAVES][3];
    logic [3:0]  n_cnt;

    // stage registers
    logic [31:0] r1_sa;
    logic [31:0] r1_xb [MAX_OCTAVES];
    logic [31:0] r1_yc [MAX_OCTAVES];
    logic [31:0] r1_zd [MAX_OCTAVES];
    logic [15:0] r1_t  [MAX_OCTAVES][3];
    logic [31:0] r1_tt [MAX_OCTAVES][3];
    logic [31:0] r2_base [MAX_OCTAVES];
    logic [15:0] r2_t  [MAX_OCTAVES][3];
    logic [15:0] r2_t3 [MAX_OCTAVES][3];
    logic [35:0] r2_p  [MAX_OCTAVES][3];
    logic [31:0] n3_hx [MAX_OCTAVES][8];
    logic [31:0] r3_hx [MAX_OCTAVES][8];
    logic [15:0] r3_t  [MAX_OCTAVES][3];
    logic [16:0] r3_w  [MAX_OCTAVES][3];
    logic [31:0] r4_hm [MAX_OCTAVES][8];
    logic [15:0] r4_t  [MAX_OCTAVES][3];
    logic [16:0] r4_w  [MAX_OCTAVES][3];
    logic signed [18:0] r5_dot [MAX_OCTAVES][8];
    logic [16:0] r5_w  [MAX_OCTAVES][3];
    logic signed [19:0] r6_x [MAX_OCTAVES][4];
    logic [16:0] r6_w  [MAX_OCTAVES][3];
    logic signed [19:0] r7_y [MAX_OCTAVES][2];
    logic [16:0] r7_w  [MAX_OCTAVES][3];
    logic signed [19:0] r8_p [MAX_OCTAVES];
    logic signed [35:0] n9_grp [NG];
    logic signed [35:0] r9_grp [NG];
    logic signed [35:0] n10_acc;
    logic signed [35:0] r10_acc;
    logic signed [35:0] r11_hi;
    logic [34:0] r11_lo;
    logic [15:0] r12_nv;
    logic [3:0]  r_n [1:10];

    logic signed [53:0] tot;
    logic signed [20:0] shv;
    logic [15:0] n12_nv;

    assign en            = !r_vld[NST] || o_noise.ready;
    assign i_point.ready = en;
    assign o_noise.valid = r_vld[NST];
    assign o_noise.noise_value = r12_nv;

    assign pt[0] = i_point.point_x;
    assign pt[1] = i_point.point_y;
    assign pt[2] = i_point.point_z;

    // lattice cell and Q0.16 fraction of every octave's scaled coordinates
    always_comb begin
        logic [31:0] c;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            for (int a = 0; a < 3; a++) begin
                c         = pt[a] << o;
                lat[o][a] = 32'($signed(c) >>> FRAC_BITS);
                fr[o][a]  = 16'(((c & FMASK) >> FSH_R) << FSH_L);
            end
        end
    end

    always_comb begin
        if (5'(r_count) > 5'(MAX_OCTAVES))
            n_cnt = 4'(MAX_OCTAVES);
        else
            n_cnt = r_count;
    end

    // corner hashes up to the first xorshift
    always_comb begin
        logic [31:0] hc;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            for (int c = 0; c < 8; c++) begin
                hc          = r2_base[o] + corner_off(c);
                n3_hx[o][c] = hc ^ (hc >> 13);
            end
        end
    end

    // masked octave terms, summed four to a group
    always_comb begin
        int o;
        for (int g = 0; g < NG; g++) begin
            n9_grp[g] = '0;
            for (int k = 0; k < 4; k++) begin
                o = 4 * g + k;
                if (o < MAX_OCTAVES && 5'(o) < {1'b0, r_n[8]})
                    n9_grp[g] = n9_grp[g] + (36'(r8_p[o]) <<< (16 - o));
            end
        end
    end

    always_comb begin
        n10_acc = '0;
        for (int g = 0; g < NG; g++)
            n10_acc = n10_acc + r9_grp[g];
    end

    // scale back to Q1.15 and saturate
    always_comb begin
        tot = (54'(r11_hi) <<< 18) + $signed({19'b0, r11_lo});
        shv = 21'(tot >>> 33);
        if (shv > 21'sd32767)
            n12_nv = 16'h7fff;
        else if (shv < -21'sd32768)
            n12_nv = 16'h8000;
        else
            n12_nv = shv[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_seed  <= '0;
            r_count <= 4'd1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NOISE_SEED:   r_seed  <= i_cfg_data;
                    REG_OCTAVE_COUNT: r_count <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (en)
                r_vld <= {r_vld[NST-1:1], i_point.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: hash products and fade squares
            r1_sa <= r_seed * H_SEED;
            r_n[1] <= n_cnt;
            for (int o = 0; o < MAX_OCTAVES; o++) begin
                r1_xb[o] <= lat[o][0] * H_X;
                r1_yc[o] <= lat[o][1] * H_Y;
                r1_zd[o] <= lat[o][2] * H_Z;
                for (int a = 0; a < 3; a++) begin
                    r1_t[o][a]  <= fr[o][a];
                    r1_tt[o][a] <= 32'(fr[o][a]) * 32'(fr[o][a]);
                end
            end
            for (int s = 2; s <= 10; s++)
                r_n[s] <= r_n[s-1];
            for (int o = 0; o < MAX_OCTAVES; o++) begin
                // stage 2: hash base and fade polynomial
                r2_base[o] <= r1_sa + 32'(o) * SEED_STEP * H_SEED
                              + r1_xb[o] + r1_yc[o] + r1_zd[o];
                for (int a = 0; a < 3; a++) begin
                    r2_t[o][a]  <= r1_t[o][a];
                    r2_t3[o][a] <= 16'((48'(r1_tt[o][a]) * 48'(r1_t[o][a])) >> 32);
                    r2_p[o][a]  <= 36'(40'(r1_tt[o][a]) * 40'd6 + (40'd10 << 32)
                                       - ((40'(r1_t[o][a]) * 40'd15) << 16));
                    // stage 3: fade weight
                    r3_t[o][a] <= r2_t[o][a];
                    r3_w[o][a] <= 17'((52'(r2_t3[o][a]) * 52'(r2_p[o][a])) >> 32);
                    r4_t[o][a] <= r3_t[o][a];
                    r4_w[o][a] <= r3_w[o][a];
                    r5_w[o][a] <= r4_w[o][a];
                    r6_w[o][a] <= r5_w[o][a];
                    r7_w[o][a] <= r6_w[o][a];
                end
                for (int c = 0; c < 8; c++) begin
                    r3_hx[o][c] <= n3_hx[o][c];
                    // stage 4: final hash multiply
                    r4_hm[o][c] <= r3_hx[o][c] * H_MIX;
                    // stage 5: gradient pick, {1,t} is t - 1.0 in Q.16
                    r5_dot[o][c] <= grad_dot(r4_hm[o][c][3:0] ^ r4_hm[o][c][19:16],
                        (c & 1) != 0 ? $signed({1'b1, r4_t[o][0]}) : $signed({1'b0, r4_t[o][0]}),
                        (c & 2) != 0 ? $signed({1'b1, r4_t[o][1]}) : $signed({1'b0, r4_t[o][1]}),
                        (c & 4) != 0 ? $signed({1'b1, r4_t[o][2]}) : $signed({1'b0, r4_t[o][2]}));
                end
                // stages 6 to 8: blend along x, y, then z
                for (int k = 0; k < 4; k++)
                    r6_x[o][k] <= lerp(20'(r5_dot[o][2*k]), 20'(r5_dot[o][2*k+1]), r5_w[o][0]);
                for (int j = 0; j < 2; j++)
                    r7_y[o][j] <= lerp(r6_x[o][2*j], r6_x[o][2*j+1], r6_w[o][1]);
                r8_p[o] <= lerp(r7_y[o][0], r7_y[o][1], r7_w[o][2]);
            end
            // stages 9 to 12: octave sum, normalization, saturation
            for (int g = 0; g < NG; g++)
                r9_grp[g] <= n9_grp[g];
            r10_acc <= n10_acc;
            r11_hi  <= 36'($signed(r10_acc[35:18]) * $signed({1'b0, norm_recip(r_n[10])}));
            r11_lo  <= 35'(r10_acc[17:0]) * 35'(norm_recip(r_n[10]));
            r12_nv  <= n12_nv;
        end
    end

endmodule
